// ===== rtl/dtc_pkg.sv =====
// Package for the drive timing counters: counter widths, reload values,
// register reset values, configuration register indexes and saturating helpers.
// No dependencies.
`default_nettype none

package dtc_pkg;

  localparam int TimeW     = 32;
  localparam int WaitW     = 11;
  localparam int MotorW    = 21;
  localparam int TransferW = 14;
  localparam int CfgIndexW = 8;

  localparam logic [WaitW-1:0]     WaitReload     = WaitW'(2000);
  localparam logic [MotorW-1:0]    MotorReload    = MotorW'(2000000);
  localparam logic [TransferW-1:0] TransferReload = TransferW'(10000);

  localparam logic [TimeW-1:0] RotationTimeReset   = TimeW'(200000);
  localparam logic [TimeW-1:0] IndexTimeReset      = TimeW'(4000);
  localparam logic [TimeW-1:0] ResetHoldTimeReset  = TimeW'(1000);
  localparam logic [TimeW-1:0] CardSettleTimeReset = TimeW'(100000);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ROTATION_TIME    = CfgIndexW'(0),
    CFG_INDEX_TIME       = CfgIndexW'(1),
    CFG_RESET_HOLD_TIME  = CfgIndexW'(2),
    CFG_CARD_SETTLE_TIME = CfgIndexW'(3)
  } cfg_index_t;

  // Add that sticks at all ones instead of wrapping.
  function automatic logic [TimeW-1:0] sat_up(input logic [TimeW-1:0] v,
                                              input logic [TimeW-1:0] d);
    logic [TimeW:0] sum;
    sum = {1'b0, v} + {1'b0, d};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

  // Subtract that stops at zero.
  function automatic logic [TimeW-1:0] sat_down(input logic [TimeW-1:0] v,
                                                input logic [TimeW-1:0] d);
    return (v > d) ? (v - d) : '0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/drive_timing_counters_top.sv =====
// Drive timing counters, top level. Depends on dtc_pkg.
// Holds the configuration registers, the input register, all counters and
// the result register.
//
// Usage: each item on the input channel is one tick with a microsecond
// timestamp, two pin levels and three reload strobes. Elapsed time is the
// timestamp difference from the previous tick, modulo 2^32. Every tick gives
// exactly one result item with six status flags.
// Channels: in_valid/in_ready for ticks, out_valid/out_ready for results,
// cfg_valid/cfg_ready with cfg_index and cfg_data for register writes.
// cfg_ready is always high; writes to indexes beyond the register list are
// ignored. Registers are to be written only while the block is idle; the
// block itself does not enforce this. An accepted item waits in the input
// register, then the counter update loads the result register. Throughput
// is one item per cycle while the receiver does not stall, set by the single
// counter update stage. When the receiver stalls, the result register holds
// and one further item waits in the input register; in_ready drops only when
// both are full. Synchronous reset clears all counters, empties both registers
// and loads the register defaults.
`default_nettype none

module drive_timing_counters_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dtc_pkg::TimeW-1:0]     now_us,
  input  wire logic                          reset_pin_low,
  input  wire logic                          card_detect,
  input  wire logic                          arm_wait,
  input  wire logic                          motor_retrigger,
  input  wire logic                          state_reload,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               wait_release,
  output logic                               motor_on,
  output logic                               index_flag,
  output logic                               reset_request,
  output logic                               card_settled,
  output logic                               state_timer_running,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dtc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [dtc_pkg::TimeW-1:0]     cfg_data
);
  import dtc_pkg::*;

  // Configuration registers
  logic [TimeW-1:0] rotation_time;
  logic [TimeW-1:0] index_time;
  logic [TimeW-1:0] reset_hold_time;
  logic [TimeW-1:0] card_settle_time;

  // Input register
  logic             s1_valid;
  logic [TimeW-1:0] s1_now;
  logic             s1_pin_low;
  logic             s1_card;
  logic             s1_arm_wait;
  logic             s1_motor_retrigger;
  logic             s1_state_reload;

  // Counter state
  logic [TimeW-1:0]     previous_time;
  logic [WaitW-1:0]     wait_count;
  logic [MotorW-1:0]    motor_count;
  logic [TimeW-1:0]     rotation_count;
  logic                 index_state;
  logic [TimeW-1:0]     reset_hold_count;
  logic                 reset_armed;
  logic [TransferW-1:0] transfer_count;
  logic [TimeW-1:0]     presence_count;

  logic [WaitW-1:0]     wait_count_next;
  logic [MotorW-1:0]    motor_count_next;
  logic [TimeW-1:0]     rotation_count_next;
  logic                 index_state_next;
  logic [TimeW-1:0]     reset_hold_count_next;
  logic                 reset_armed_next;
  logic [TransferW-1:0] transfer_count_next;
  logic [TimeW-1:0]     presence_count_next;
  logic                 release_next;
  logic                 motor_on_next;
  logic                 request_next;

  logic             advance;
  logic [TimeW-1:0] diff;
  logic [WaitW-1:0]     wait_loaded;
  logic [MotorW-1:0]    motor_loaded;
  logic [TransferW-1:0] transfer_loaded;
  logic [TimeW-1:0]     rotation_sum;
  logic [TimeW-1:0]     hold_sum;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_time    <= RotationTimeReset;
      index_time       <= IndexTimeReset;
      reset_hold_time  <= ResetHoldTimeReset;
      card_settle_time <= CardSettleTimeReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROTATION_TIME:    rotation_time    <= cfg_data;
        CFG_INDEX_TIME:       index_time       <= cfg_data;
        CFG_RESET_HOLD_TIME:  reset_hold_time  <= cfg_data;
        CFG_CARD_SETTLE_TIME: card_settle_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now             <= now_us;
      s1_pin_low         <= reset_pin_low;
      s1_card            <= card_detect;
      s1_arm_wait        <= arm_wait;
      s1_motor_retrigger <= motor_retrigger;
      s1_state_reload    <= state_reload;
    end
  end

  assign diff = s1_now - previous_time;

  always_comb begin
    wait_loaded     = s1_arm_wait ? WaitReload : wait_count;
    motor_loaded    = s1_motor_retrigger ? MotorReload : motor_count;
    transfer_loaded = s1_state_reload ? TransferReload : transfer_count;

    // A counter at zero stays at zero under the saturating subtract, so the
    // nonzero guards reduce to the subtract itself.
    wait_count_next     = WaitW'(sat_down(TimeW'(wait_loaded), diff));
    release_next        = (wait_loaded != '0) && (wait_count_next == '0);
    transfer_count_next = TransferW'(sat_down(TimeW'(transfer_loaded), diff));

    motor_on_next       = (motor_loaded != '0);
    motor_count_next    = MotorW'(sat_down(TimeW'(motor_loaded), diff));
    rotation_sum        = sat_up(rotation_count, diff);
    rotation_count_next = rotation_count;
    index_state_next    = index_state;
    if (motor_on_next) begin
      rotation_count_next = (rotation_sum >= rotation_time) ?
                            (rotation_sum - rotation_time) : rotation_sum;
      index_state_next    = (rotation_count_next < index_time);
    end

    hold_sum              = sat_up(reset_hold_count, diff);
    reset_hold_count_next = reset_hold_count;
    reset_armed_next      = reset_armed;
    request_next          = 1'b0;
    if (s1_pin_low) begin
      if (reset_armed) begin
        reset_hold_count_next = hold_sum;
        request_next          = (hold_sum >= reset_hold_time);
      end
    end else begin
      reset_hold_count_next = '0;
      reset_armed_next      = 1'b1;
    end

    presence_count_next = presence_count;
    if (!s1_card) begin
      presence_count_next = '0;
    end else if (presence_count < card_settle_time) begin
      presence_count_next = sat_up(presence_count, diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time    <= '0;
      wait_count       <= '0;
      motor_count      <= '0;
      rotation_count   <= '0;
      index_state      <= 1'b0;
      reset_hold_count <= '0;
      reset_armed      <= 1'b0;
      transfer_count   <= '0;
      presence_count   <= '0;
      out_valid        <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        previous_time    <= s1_now;
        wait_count       <= wait_count_next;
        motor_count      <= motor_count_next;
        rotation_count   <= rotation_count_next;
        index_state      <= index_state_next;
        reset_hold_count <= reset_hold_count_next;
        reset_armed      <= reset_armed_next;
        transfer_count   <= transfer_count_next;
        presence_count   <= presence_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      wait_release        <= release_next;
      motor_on            <= motor_on_next;
      index_flag          <= index_state_next;
      reset_request       <= request_next;
      card_settled        <= (presence_count_next >= card_settle_time);
      state_timer_running <= (transfer_count_next != '0);
    end
  end

  // State only moves together with the result register, so a shown result
  // always matches the counters it was computed with.
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_release |-> wait_count == '0)
    else $error("wait release shown with nonzero wait count");

  a_state_running: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state_timer_running == (transfer_count != '0))
    else $error("state timer flag disagrees with transfer count");

  a_request_armed: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_request |-> reset_armed)
    else $error("reset request without arming");

  a_index_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> index_flag == index_state)
    else $error("index flag disagrees with index state");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled while a register was free");

endmodule

`default_nettype wire

// ===== sim/tb_drive_timing_counters_top.sv =====
// Self-checking testbench for drive_timing_counters_top: random and directed ticks,
// register writes between phases, and a per-tick predictor of the six result flags.
// Depends on dtc_pkg and the RTL top level only.
module tb_drive_timing_counters_top;
  import dtc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [CfgIndexW-1:0] CfgIndexUnused = '1;

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic             reset_pin_low;
    logic             card_detect;
    logic             arm_wait;
    logic             motor_retrigger;
    logic             state_reload;
  } tick_t;

  typedef struct packed {
    logic wait_release;
    logic motor_on;
    logic index_flag;
    logic reset_request;
    logic card_settled;
    logic state_timer_running;
  } flags_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TimeW-1:0]     now_us = '0;
  logic                 reset_pin_low = 1'b0;
  logic                 card_detect = 1'b0;
  logic                 arm_wait = 1'b0;
  logic                 motor_retrigger = 1'b0;
  logic                 state_reload = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 wait_release;
  logic                 motor_on;
  logic                 index_flag;
  logic                 reset_request;
  logic                 card_settled;
  logic                 state_timer_running;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [TimeW-1:0]     cfg_data = '0;

  drive_timing_counters_top u_top (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .now_us              (now_us),
    .reset_pin_low       (reset_pin_low),
    .card_detect         (card_detect),
    .arm_wait            (arm_wait),
    .motor_retrigger     (motor_retrigger),
    .state_reload        (state_reload),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .wait_release        (wait_release),
    .motor_on            (motor_on),
    .index_flag          (index_flag),
    .reset_request       (reset_request),
    .card_settled        (card_settled),
    .state_timer_running (state_timer_running),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of the configuration registers and counters.
  logic [TimeW-1:0]     rot_time_r    = RotationTimeReset;
  logic [TimeW-1:0]     idx_time_r    = IndexTimeReset;
  logic [TimeW-1:0]     hold_time_r   = ResetHoldTimeReset;
  logic [TimeW-1:0]     settle_time_r = CardSettleTimeReset;
  logic [TimeW-1:0]     last_stamp    = '0;
  logic [WaitW-1:0]     wait_cnt      = '0;
  logic [MotorW-1:0]    motor_cnt     = '0;
  logic [TimeW-1:0]     rot_cnt       = '0;
  logic                 index_on      = 1'b0;
  logic [TimeW-1:0]     hold_cnt      = '0;
  logic                 armed         = 1'b0;
  logic [TransferW-1:0] xfer_cnt      = '0;
  logic [TimeW-1:0]     presence_cnt  = '0;

  flags_t expected_flags_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 73;

  // Stimulus-side memory: last timestamp sent and the slowly changing pin levels.
  logic [TimeW-1:0] last_sent_stamp = '0;
  logic             stim_pin_low = 1'b1;
  logic             stim_card = 1'b0;

  function automatic logic [TimeW-1:0] clamp_sub(input logic [TimeW-1:0] v,
                                                 input logic [TimeW-1:0] d);
    return (v > d) ? v - d : '0;
  endfunction

  function automatic logic [TimeW-1:0] clamp_add(input logic [TimeW-1:0] v,
                                                 input logic [TimeW-1:0] d);
    logic [TimeW:0] sum;
    sum = {1'b0, v} + {1'b0, d};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

  task automatic advance_drive_timers(input tick_t t);
    logic [TimeW-1:0] elapsed;
    flags_t f;
    elapsed = t.now_us - last_stamp;
    last_stamp = t.now_us;
    f = '0;
    if (t.arm_wait) wait_cnt = WaitReload;
    if (t.motor_retrigger) motor_cnt = MotorReload;
    if (t.state_reload) xfer_cnt = TransferReload;
    if (wait_cnt != '0) begin
      wait_cnt = WaitW'(clamp_sub(TimeW'(wait_cnt), elapsed));
      f.wait_release = (wait_cnt == '0);
    end
    if (motor_cnt != '0) begin
      f.motor_on = 1'b1;
      motor_cnt = MotorW'(clamp_sub(TimeW'(motor_cnt), elapsed));
      rot_cnt = clamp_add(rot_cnt, elapsed);
      // Only one rotation is taken off per tick, even after a long gap.
      if (rot_cnt >= rot_time_r) rot_cnt = rot_cnt - rot_time_r;
      index_on = (rot_cnt < idx_time_r);
    end
    if (t.reset_pin_low) begin
      if (armed) begin
        hold_cnt = clamp_add(hold_cnt, elapsed);
        f.reset_request = (hold_cnt >= hold_time_r);
      end
    end else begin
      hold_cnt = '0;
      armed = 1'b1;
    end
    if (xfer_cnt != '0) xfer_cnt = TransferW'(clamp_sub(TimeW'(xfer_cnt), elapsed));
    if (t.card_detect) begin
      if (presence_cnt < settle_time_r) presence_cnt = clamp_add(presence_cnt, elapsed);
    end else begin
      presence_cnt = '0;
    end
    f.index_flag = index_on;
    f.card_settled = (presence_cnt >= settle_time_r);
    f.state_timer_running = (xfer_cnt != '0);
    expected_flags_q.push_back(f);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %b want %b", result_count, name, got, want));
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_flags
    flags_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_flags_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no tick pending", result_count));
      end else begin
        want = expected_flags_q.pop_front();
        check_field("wait_release", wait_release, want.wait_release);
        check_field("motor_on", motor_on, want.motor_on);
        check_field("index_flag", index_flag, want.index_flag);
        check_field("reset_request", reset_request, want.reset_request);
        check_field("card_settled", card_settled, want.card_settled);
        check_field("state_timer_running", state_timer_running, want.state_timer_running);
      end
      result_count++;
    end
  end

  // Called at a falling edge; returns at a falling edge with in_valid still high.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    now_us          <= t.now_us;
    reset_pin_low   <= t.reset_pin_low;
    card_detect     <= t.card_detect;
    arm_wait        <= t.arm_wait;
    motor_retrigger <= t.motor_retrigger;
    state_reload    <= t.state_reload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_drive_timers(t);
    last_sent_stamp = t.now_us;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_flags_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes follow without a gap.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [TimeW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROTATION_TIME:    rot_time_r = val;
      CFG_INDEX_TIME:       idx_time_r = val;
      CFG_RESET_HOLD_TIME:  hold_time_r = val;
      CFG_CARD_SETTLE_TIME: settle_time_r = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [TimeW-1:0] rot, input logic [TimeW-1:0] idx,
                            input logic [TimeW-1:0] hold, input logic [TimeW-1:0] settle);
    drain_results();
    write_reg(CFG_ROTATION_TIME, rot);
    write_reg(CFG_INDEX_TIME, idx);
    write_reg(CFG_RESET_HOLD_TIME, hold);
    write_reg(CFG_CARD_SETTLE_TIME, settle);
    // Writes past the register list must leave every register alone.
    write_reg(CfgIndexUnused, $urandom);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic tick_t mk_tick(input logic [TimeW-1:0] stamp, input logic pin_low,
                                    input logic card, input logic arm, input logic motor,
                                    input logic reload);
    tick_t t;
    t.now_us = stamp;
    t.reset_pin_low = pin_low;
    t.card_detect = card;
    t.arm_wait = arm;
    t.motor_retrigger = motor;
    t.state_reload = reload;
    return t;
  endfunction

  function automatic tick_t make_random_tick();
    tick_t t;
    int unsigned sel;
    logic [TimeW-1:0] delta;
    sel = $urandom_range(99);
    if (sel < 10) delta = '0;
    else if (sel < 45) delta = $urandom_range(600);
    else if (sel < 70) delta = $urandom_range(5000);
    else if (sel < 85) delta = $urandom_range(250000);
    else if (sel < 95) delta = $urandom_range(3000000);
    else delta = $urandom;
    if ($urandom_range(99) < 15) stim_pin_low = ~stim_pin_low;
    if ($urandom_range(99) < 8) stim_card = ~stim_card;
    t = mk_tick(last_sent_stamp + delta, stim_pin_low, stim_card,
                $urandom_range(99) < 12, $urandom_range(99) < 6, $urandom_range(99) < 10);
    // A few ticks are pure noise on every field.
    if ($urandom_range(99) < 5) t = tick_t'({$urandom, 5'($urandom)});
    return t;
  endfunction

  task automatic test_directed_ticks();
    send_tick(mk_tick(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));     // pin low before ever high
    send_tick(mk_tick(32'd5000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(32'd5000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // arm, zero elapsed
    send_tick(mk_tick(32'd6999, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));  // hold past threshold
    send_tick(mk_tick(32'd7000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));  // wait reaches zero
    send_tick(mk_tick(32'd7100, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
    send_tick(mk_tick(32'd11100, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(32'd207000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)); // exact rotation wrap
    send_tick(mk_tick(32'd207010, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // card removed
    send_tick(mk_tick(32'h8003_2896, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(32'h8003_28A0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)); // motor stopped
    send_tick(mk_tick(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
    send_tick(mk_tick(32'h0000_0010, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1)); // timestamp wraps
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    drain_results();
  endtask

  task automatic test_register_extremes();
    // Zero rotation time, index time, hold time and settle time.
    set_config('0, '0, '0, '0);
    send_tick(mk_tick(last_sent_stamp + 10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(last_sent_stamp, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(last_sent_stamp + 32'h4000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(last_sent_stamp + 300, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
    // All-ones registers: up-counters have to stick at their ceiling.
    set_config('1, '1, '1, '1);
    send_tick(mk_tick(last_sent_stamp + 5, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    repeat (4)
      send_tick(mk_tick(last_sent_stamp + 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    logic [TimeW-1:0] rot;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 12; recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 2; ph++) begin
        phase = mode * 2 + ph;
        case (phase)
          0: set_config(RotationTimeReset, IndexTimeReset, ResetHoldTimeReset,
                        CardSettleTimeReset);
          1: begin
            rot = $urandom_range(20000, 1);
            set_config(rot, $urandom_range(rot), $urandom_range(5000), $urandom_range(50000));
          end
          2: set_config('1, '1, '1, '1);
          3: set_config(32'd1, '0, '0, '0);
          4: set_config($urandom, $urandom, $urandom, $urandom);
          default: begin
            rot = $urandom_range(400000, 100000);
            set_config(rot, $urandom_range(rot), $urandom_range(3000, 500),
                       $urandom_range(200000, 10000));
          end
        endcase
        for (int n = 0; n < 217; n++) begin
          // Let the pipeline run empty once per phase before carrying on.
          if (n == 100) drain_results();
          send_tick(make_random_tick());
        end
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_ticks();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_flags_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dtc_pkg.sv
rtl/drive_timing_counters_top.sv
sim/tb_drive_timing_counters_top.sv
